/* rtl/core/signed_decimal_display_formatter_top_macros.svh */
// Assertion macros for the signed decimal display formatter.
// Used by modules that include this header; they need aclk and aresetn in scope.
`ifndef SIGNED_DECIMAL_DISPLAY_FORMATTER_TOP_MACROS_SVH
`define SIGNED_DECIMAL_DISPLAY_FORMATTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SDF_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sdf assertion failed");
`define SDF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sdf assertion failed");
`else
`define SDF_ASSERT_IMPL(name, ante, cons)
`define SDF_ASSERT_NEXT(name, ante, cons)
`endif

`endif

/* rtl/core/sdf_pkg.sv */
// Shared constants, symbol codes and types of the signed decimal display formatter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sdf_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int NUMBER_W    = 32;
    localparam int NUM_POS     = 8;
    localparam int POS_W       = 3;
    localparam int SYM_W       = 4;

    // Largest magnitude that still fits on the display.
    localparam int OVF_LIMIT = 10 ** DIGIT_COUNT - 1;
    localparam int MAG_W     = $clog2(OVF_LIMIT + 1);

    // Reciprocal of ten, exact for every 32-bit dividend.
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [POS_W-1:0] K_LAST = POS_W'(NUM_POS - 1);

    localparam logic [SYM_W-1:0] SYM_MINUS = 4'd10;
    localparam logic [SYM_W-1:0] SYM_BLANK = 4'd11;
    localparam logic [SYM_W-1:0] SYM_OVF   = 4'd12;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [MAG_W-1:0] mag;
    } sdf_item_t;

endpackage

/* rtl/core/sdf_in_stage.sv */
// Input register of the formatter: holds one number and splits it into sign,
// magnitude and overflow flag. Depends on sdf_pkg.
`timescale 1ns / 1ps

module sdf_in_stage
    import sdf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [NUMBER_W-1:0] s_axis_tdata,
    output logic                item_valid,
    input  logic                item_take,
    output sdf_item_t           item
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [NUMBER_W-1:0] in_number_reg;
    logic [NUMBER_W-1:0] mag_full;
    logic                accept;

    assign s_axis_tready = !in_valid_reg || item_take;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign item_valid    = in_valid_reg;

    always_comb begin
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (item_take) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    // The most negative number negates to itself, which reads correctly as unsigned.
    always_comb begin
        item.neg = in_number_reg[NUMBER_W-1];
        mag_full = item.neg ? (NUMBER_W'(0) - in_number_reg) : in_number_reg;
        item.ovf = mag_full > NUMBER_W'(OVF_LIMIT);
        item.mag = mag_full[MAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_number_reg <= s_axis_tdata;
        end
    end

endmodule

/* rtl/core/sdf_div10.sv */
// Divides a magnitude by ten with a reciprocal multiply and yields the remainder digit.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

module sdf_div10
    import sdf_pkg::*;
(
    input  logic [MAG_W-1:0] mag,
    output logic [MAG_W-1:0] quot,
    output logic [SYM_W-1:0] digit
);

    logic [MAG_W+31:0] prod;
    logic [MAG_W+31:0] prod_shifted;
    logic [MAG_W-1:0]  rem;

    always_comb begin
        prod         = (MAG_W + 32)'(mag) * (MAG_W + 32)'(RECIP10);
        prod_shifted = prod >> RECIP_SHIFT;
        quot         = prod_shifted[MAG_W-1:0];
        // Ten times the quotient as two shifted copies.
        rem          = mag - ((quot << 3) + (quot << 1));
        digit        = rem[SYM_W-1:0];
    end

endmodule

/* rtl/core/sdf_emitter.sv */
// Position sequencer and result register: walks the eight display positions of a
// number, one per unstalled cycle. Depends on sdf_pkg, sdf_div10, assertion macros.
`timescale 1ns / 1ps
`include "signed_decimal_display_formatter_top_macros.svh"

module sdf_emitter
    import sdf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    output logic             item_take,
    input  sdf_item_t        item,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [POS_W-1:0] m_pos,
    output logic [SYM_W-1:0] m_sym,
    output logic             m_last
);

    logic             busy_reg,  busy_next;
    logic [POS_W-1:0] k_reg,     k_next;
    logic [MAG_W-1:0] mag_reg,   mag_next;
    logic             minus_reg, minus_next;
    logic             ovf_reg,   ovf_next;
    logic             m_valid_reg, m_valid_next;
    logic [POS_W-1:0] m_pos_reg;
    logic [SYM_W-1:0] m_sym_reg;
    logic             m_last_reg;

    logic             out_free;
    logic             step;
    logic             load;
    logic [MAG_W-1:0] quot;
    logic [SYM_W-1:0] digit;
    logic [POS_W-1:0] pos;
    logic [SYM_W-1:0] sym;

    sdf_div10 u_div10 (
        .mag   (mag_reg),
        .quot  (quot),
        .digit (digit)
    );

    assign m_valid = m_valid_reg;
    assign m_pos   = m_pos_reg;
    assign m_sym   = m_sym_reg;
    assign m_last  = m_last_reg;

    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        step      = busy_reg && out_free;
        // The next number loads on the same edge as the final position of this one.
        load      = item_valid && (!busy_reg || (step && k_reg == K_LAST));
        item_take = load;

        if (ovf_reg) begin
            pos = k_reg;
            sym = SYM_OVF;
        end else begin
            pos = K_LAST - k_reg;
            if (mag_reg != '0 || k_reg == '0) begin
                sym = digit;
            end else if (minus_reg) begin
                sym = SYM_MINUS;
            end else begin
                sym = SYM_BLANK;
            end
        end

        busy_next    = busy_reg;
        k_next       = k_reg;
        mag_next     = mag_reg;
        minus_next   = minus_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;

        if (step) begin
            m_valid_next = 1'b1;
            k_next       = k_reg + POS_W'(1);
            mag_next     = quot;
            if (sym == SYM_MINUS) begin
                minus_next = 1'b0;
            end
            if (k_reg == K_LAST) begin
                busy_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (load) begin
            busy_next  = 1'b1;
            k_next     = '0;
            mag_next   = item.mag;
            minus_next = item.neg;
            ovf_next   = item.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg   <= mag_next;
        minus_reg <= minus_next;
        ovf_reg   <= ovf_next;
        if (step) begin
            m_pos_reg  <= pos;
            m_sym_reg  <= sym;
            m_last_reg <= (k_reg == K_LAST);
        end
    end

    // A stalled result register must freeze the position count.
    `SDF_ASSERT_NEXT(a_k_holds_on_stall, busy_reg && !out_free, $stable(k_reg))
    // Loading a number always restarts the sequence at its first position.
    `SDF_ASSERT_NEXT(a_load_restarts, load, busy_reg && k_reg == '0)
    // The first result of a number in range is a decimal digit.
    `SDF_ASSERT_NEXT(a_first_is_digit, step && k_reg == '0 && !ovf_reg, m_sym_reg <= 4'd9)
    // The final result sits at the leftmost position, or the rightmost on overflow.
    `SDF_ASSERT_IMPL(a_last_position, m_valid_reg && m_last_reg,
        m_pos_reg == ((m_sym_reg == SYM_OVF) ? K_LAST : '0))

endmodule

/* rtl/core/signed_decimal_display_formatter_top.sv */
// Signed decimal display formatter: one signed number in, eight display positions out.
// A number crosses the input, working and result registers to its first position.
// One position per cycle when the output channel accepts; the position sequencer
// and the output channel set this, and numbers follow with no gap.
// Reset (aresetn low, synchronous) empties the input and result registers.
`timescale 1ns / 1ps

module signed_decimal_display_formatter_top
    import sdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] position, [6:3] symbol, [7] zero
    output logic        m_axis_tlast
);

    logic             item_valid;
    logic             item_take;
    sdf_item_t        item;
    logic [POS_W-1:0] pos;
    logic [SYM_W-1:0] sym;

    sdf_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .item_valid    (item_valid),
        .item_take     (item_take),
        .item          (item)
    );

    sdf_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_pos      (pos),
        .m_sym      (sym),
        .m_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, sym, pos};

endmodule

/* test/testbench.sv */
// Self-checking testbench for signed_decimal_display_formatter_top.
// Drives signed numbers into the stream input and checks every display position against
// a predictor of its own. Depends only on sdf_pkg and the top module of the block.
`timescale 1ns / 1ps

module testbench;
    import sdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_ITEMS   = 150;

    typedef struct {
        logic [POS_W-1:0] position;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } display_pos_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    logic [31:0]  pending_numbers[$];
    display_pos_t wanted_positions[$];

    int send_idle_pct;
    int recv_idle_pct;
    int numbers_sent;
    int numbers_taken;
    int positions_seen;
    int overflow_numbers;
    int negative_numbers;
    int error_count;
    int quiet_cycles;

    signed_decimal_display_formatter_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint display_limit();
        longint lim;
        int     n;
        lim = 1;
        n = DIGIT_COUNT;
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        for (int i = 0; i < n; i++) lim = lim * 10;
        return lim - 1;
    endfunction

    // Works out the eight positions that one number produces and queues them.
    function automatic void format_number(input logic [31:0] number);
        logic         negative;
        logic         minus_left;
        logic [31:0]  magnitude;
        display_pos_t r;
        negative = number[31];
        magnitude = negative ? (32'd0 - number) : number;
        minus_left = negative;
        if (longint'(magnitude) > display_limit()) begin
            overflow_numbers++;
            for (int k = 0; k < NUM_POS; k++) begin
                r.position = POS_W'(k);
                r.symbol = SYM_OVF;
                r.last = (k == NUM_POS - 1);
                wanted_positions.push_back(r);
            end
        end else begin
            for (int k = 0; k < NUM_POS; k++) begin
                r.position = POS_W'(NUM_POS - 1 - k);
                r.last = (k == NUM_POS - 1);
                if (magnitude != 0 || k == 0) begin
                    r.symbol = SYM_W'(magnitude % 10);
                    magnitude = magnitude / 10;
                end else if (minus_left) begin
                    r.symbol = SYM_MINUS;
                    minus_left = 1'b0;
                end else begin
                    r.symbol = SYM_BLANK;
                end
                wanted_positions.push_back(r);
            end
        end
    endfunction

    // Mostly numbers of a chosen digit count and sign, plus raw 32-bit words and edge values.
    function automatic logic [31:0] random_number();
        int          kind;
        int          digits;
        longint      lo;
        longint      hi;
        logic [31:0] mag;
        kind = $urandom_range(0, 9);
        if (kind < 2) return $urandom();
        if (kind == 2) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000 + $urandom_range(0, 3);
                1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
                2: return 32'd99999999 + $urandom_range(0, 2) - 1;
                default: return 32'd0 - (32'd99999999 + $urandom_range(0, 2) - 1);
            endcase
        end
        digits = $urandom_range(1, 8);
        hi = 1;
        for (int i = 0; i < digits; i++) hi = hi * 10;
        lo = (digits == 1) ? 0 : hi / 10;
        mag = 32'(lo + longint'($urandom_range(0, 32'(hi - lo - 1))));
        return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
    endfunction

    task automatic wait_for_drain();
        while (numbers_taken != numbers_sent || wanted_positions.size() != 0)
            @(posedge aclk);
    endtask

    task automatic queue_number(input logic [31:0] number);
        pending_numbers.push_back(number);
        numbers_sent++;
    endtask

    // Driver: holds a request until it is taken, then may idle before the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_numbers.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: predicts on each accepted number and checks each accepted position.
    always @(posedge aclk) begin
        display_pos_t w;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                numbers_taken++;
                if (s_axis_tdata[31]) negative_numbers++;
                format_number(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                positions_seen++;
                if (wanted_positions.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tlast=%b",
                             $time, m_axis_tdata, m_axis_tlast);
                    error_count++;
                end else begin
                    w = wanted_positions.pop_front();
                    if (m_axis_tdata[2:0] !== w.position) begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, w.position, m_axis_tdata[2:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[6:3] !== w.symbol) begin
                        $display("%0t: symbol at position %0d expected %0d actual %0d",
                                 $time, w.position, w.symbol, m_axis_tdata[6:3]);
                        error_count++;
                    end
                    if (m_axis_tlast !== w.last) begin
                        $display("%0t: last at position %0d expected %b actual %b",
                                 $time, w.position, w.last, m_axis_tlast);
                        error_count++;
                    end
                    if (m_axis_tdata[7] !== 1'b0) begin
                        $display("%0t: padding bit expected 0 actual %b",
                                 $time, m_axis_tdata[7]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, wanted_positions.size());
            $display("signed_decimal_display_formatter_top: mismatch");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 72;
        numbers_sent = 0;
        numbers_taken = 0;
        positions_seen = 0;
        overflow_numbers = 0;
        negative_numbers = 0;
        error_count = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero, single digits, the display limit on both sides, the minus sign landing on
        // position 0, full-width negatives that lose their sign, and the 32-bit extremes.
        queue_number(32'd0);
        queue_number(32'd1);
        queue_number(32'hFFFF_FFFF);
        queue_number(32'd9);
        queue_number(32'd0 - 32'd9);
        queue_number(32'd10);
        queue_number(32'd0 - 32'd100);
        queue_number(32'd1234567);
        queue_number(32'd0 - 32'd1234567);
        queue_number(32'd10000000);
        queue_number(32'd12345678);
        queue_number(32'd0 - 32'd12345678);
        queue_number(32'd99999999);
        queue_number(32'd0 - 32'd99999999);
        queue_number(32'd100000000);
        queue_number(32'd0 - 32'd100000000);
        queue_number(32'h8000_0000);
        queue_number(32'h8000_0001);
        queue_number(32'h7FFF_FFFF);
        queue_number(32'h5555_5555);
        queue_number(32'hAAAA_AAAA);
        for (int i = 0; i < RANDOM_ITEMS / 3; i++) queue_number(random_number());
        wait_for_drain();

        // The sender has paused until every position of the last phase came back.
        send_idle_pct = 72;
        recv_idle_pct = 24;
        for (int i = 0; i < RANDOM_ITEMS / 3; i++) queue_number(random_number());
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); i++)
            queue_number(random_number());
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (wanted_positions.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, wanted_positions.size());
            error_count++;
        end
        $display("Covered %0d numbers (%0d negative, %0d past the display limit), %0d positions.",
                 numbers_taken, negative_numbers, overflow_numbers, positions_seen);
        $display("Idling ran sender-light, receiver-light and back-to-back; %0d errors.",
                 error_count);
        if (error_count == 0) begin
            $display("signed_decimal_display_formatter_top: match");
        end else begin
            $display("signed_decimal_display_formatter_top: mismatch");
        end
        $finish;
    end

endmodule
